// ===== rtl/packed_bitmap_rectangle_fill_defines.svh =====
// Assertion macros shared by the bitmap fill RTL
`ifndef PACKED_BITMAP_RECTANGLE_FILL_DEFINES_SVH
`define PACKED_BITMAP_RECTANGLE_FILL_DEFINES_SVH
`ifndef SYNTHESIS
`define PBRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbrf assertion failed");
`define PBRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbrf assertion failed");
`else
`define PBRF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PBRF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/pbrf_pkg.sv =====
// Shared constants, codes and control structs for the bitmap fill block
package pbrf_pkg;
    localparam int MEM_BYTES = 1024;
    localparam int ADDR_W = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int FILL_W = 20;
    localparam int ROW_BYTES_W = 7;
    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 7'd7;
    localparam int COL_W = 8;
    localparam int ROWS_W = 11;
    localparam int XLAST_W = 11;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_FILL  = 2'd2
    } mode_t;

    typedef struct packed {
        logic clr;
        logic in_ready;
        logic byte_wr;
        logic byte_rd;
        logic fill_rd;
        logic fill_wr;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic  in_valid;
        mode_t mode;
        logic  empty;
        logic  fill_oor;
        logic  fill_last;
        logic  clr_last;
        logic  out_free;
    } sts_t;
endpackage

// ===== rtl/pbrf_in_if.sv =====
// Request channel: valid/ready handshake with the operation fields
interface pbrf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [9:0] byte_address;
    logic [7:0] write_byte;
    logic [8:0] x_start;
    logic [9:0] y_start;
    logic [9:0] rect_width;
    logic [10:0] rect_height;
    logic       set_bits;

    modport source (
        output valid, mode, byte_address, write_byte, x_start, y_start,
               rect_width, rect_height, set_bits,
        input  ready
    );
    modport sink (
        input  valid, mode, byte_address, write_byte, x_start, y_start,
               rect_width, rect_height, set_bits,
        output ready
    );
endinterface

// ===== rtl/pbrf_out_if.sv =====
// Response channel: valid/ready handshake with the result fields
interface pbrf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       out_of_range;

    modport source (
        output valid, read_byte, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, read_byte, out_of_range,
        output ready
    );
endinterface

// ===== rtl/pbrf_ram.sv =====
// Generic single-port RAM with registered read
module pbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/pbrf_ctrl.sv =====
// Sequencer for clearing, byte access and rectangle fill
`include "packed_bitmap_rectangle_fill_defines.svh"
module pbrf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  pbrf_pkg::sts_t sts,
    output pbrf_pkg::cmd_t cmd
);
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_BYTE_WR,
        ST_BYTE_RD,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.mode)
                    pbrf_pkg::MODE_WRITE: state_next = ST_BYTE_WR;
                    pbrf_pkg::MODE_READ:  state_next = ST_BYTE_RD;
                    pbrf_pkg::MODE_FILL:  state_next = sts.empty ? ST_DONE : ST_FILL_RD;
                    default:              state_next = ST_DONE;
                endcase
            end
            ST_BYTE_WR: state_next = ST_DONE;
            ST_BYTE_RD: state_next = ST_DONE;
            ST_FILL_RD:
            begin
                if (!sts.fill_oor)
                begin
                    state_next = ST_FILL_WR;
                end
                else if (sts.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL_WR: state_next = sts.fill_last ? ST_DONE : ST_FILL_RD;
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.clr      = (state_reg == ST_CLEAR);
        cmd.in_ready = (state_reg == ST_IDLE);
        cmd.byte_wr  = (state_reg == ST_BYTE_WR);
        cmd.byte_rd  = (state_reg == ST_BYTE_RD);
        cmd.fill_rd  = (state_reg == ST_FILL_RD);
        cmd.fill_wr  = (state_reg == ST_FILL_WR);
        cmd.finish   = (state_reg == ST_DONE);
    end

    `PBRF_ASSERT_NXT(a_done_to_idle, clk, rst_n, (state_reg == ST_DONE) && sts.out_free, state_reg == ST_IDLE)
    `PBRF_ASSERT_NXT(a_rd_to_wr, clk, rst_n, (state_reg == ST_FILL_RD) && !sts.fill_oor, state_reg == ST_FILL_WR)
    `PBRF_ASSERT_NXT(a_wr_exit, clk, rst_n, state_reg == ST_FILL_WR, (state_reg == ST_FILL_RD) || (state_reg == ST_DONE))
endmodule

// ===== rtl/pbrf_datapath.sv =====
// Bitmap storage, address walk, pixel masking and result register
`include "packed_bitmap_rectangle_fill_defines.svh"
module pbrf_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pbrf_pkg::ROW_BYTES_W-1:0]     cfg_wdata,
    pbrf_in_if.sink                              req,
    pbrf_out_if.source                           rsp,
    input  pbrf_pkg::cmd_t                       cmd,
    output pbrf_pkg::sts_t                       sts
);
    localparam int AW = pbrf_pkg::ADDR_W;
    localparam int FW = pbrf_pkg::FILL_W;
    localparam int CW = pbrf_pkg::COL_W;
    localparam int RW = pbrf_pkg::ROWS_W;
    localparam int XW = pbrf_pkg::XLAST_W;

    logic [pbrf_pkg::ROW_BYTES_W-1:0] row_bytes_reg;
    logic [AW-1:0]    clr_cnt_reg;
    pbrf_pkg::mode_t  mode_reg;
    logic [9:0]       addr_reg;
    logic [7:0]       wbyte_reg;
    logic             set_reg;
    logic             empty_reg;
    logic             flag_reg;
    logic             flag_next;
    logic [FW-1:0]    rowbase_reg;
    logic [CW-1:0]    b_reg;
    logic [CW-1:0]    bfirst_reg;
    logic [CW-1:0]    blast_reg;
    logic [2:0]       lo_reg;
    logic [2:0]       hi_reg;
    logic [RW-1:0]    rows_left_reg;
    logic             out_valid_reg;
    logic [7:0]       read_byte_reg;
    logic             oor_reg;

    logic          accept;
    logic          advance;
    logic          out_load;
    logic [XW-1:0] xlast;
    logic [FW-1:0] byte_addr_wide;
    logic          byte_oor;
    logic [FW-1:0] fill_addr;
    logic          fill_oor;
    logic          at_first;
    logic          at_last_col;
    logic          fill_last;
    logic [2:0]    lo;
    logic [2:0]    hi;
    logic [7:0]    mask;
    logic [7:0]    modified;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign accept   = cmd.in_ready & req.valid;
    assign out_load = cmd.finish & (!out_valid_reg | rsp.ready);
    assign xlast    = XW'(req.x_start) + XW'(req.rect_width) - XW'(1);

    assign byte_addr_wide = FW'(addr_reg);
    assign byte_oor       = byte_addr_wide >= FW'(pbrf_pkg::MEM_BYTES);
    assign fill_addr      = rowbase_reg + FW'(b_reg);
    assign fill_oor       = fill_addr >= FW'(pbrf_pkg::MEM_BYTES);
    assign at_first       = (b_reg == bfirst_reg);
    assign at_last_col    = (b_reg == blast_reg);
    assign fill_last      = at_last_col && (rows_left_reg == RW'(1));
    assign lo             = at_first ? lo_reg : 3'd0;
    assign hi             = at_last_col ? hi_reg : 3'd7;
    assign mask           = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
    assign modified       = set_reg ? (ram_rdata | mask) : (ram_rdata & ~mask);
    assign advance        = (cmd.fill_rd && fill_oor) || cmd.fill_wr;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = '0;
        ram_wdata = '0;
        if (cmd.clr)
        begin
            ram_we   = 1'b1;
            ram_addr = clr_cnt_reg;
        end
        else if (cmd.byte_wr)
        begin
            ram_we    = !byte_oor;
            ram_addr  = byte_addr_wide[AW-1:0];
            ram_wdata = wbyte_reg;
        end
        else if (cmd.byte_rd)
        begin
            ram_re   = !byte_oor;
            ram_addr = byte_addr_wide[AW-1:0];
        end
        else if (cmd.fill_rd)
        begin
            ram_re   = !fill_oor;
            ram_addr = fill_addr[AW-1:0];
        end
        else if (cmd.fill_wr)
        begin
            ram_we    = 1'b1;
            ram_addr  = fill_addr[AW-1:0];
            ram_wdata = modified;
        end
    end

    pbrf_ram #(
        .WIDTH (8),
        .DEPTH (pbrf_pkg::MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        flag_next = flag_reg;
        if (accept)
        begin
            flag_next = 1'b0;
        end
        else if ((cmd.byte_wr || cmd.byte_rd) && byte_oor)
        begin
            flag_next = 1'b1;
        end
        else if (cmd.fill_rd && fill_oor)
        begin
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= pbrf_pkg::ROW_BYTES_RST;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_bytes_reg <= cfg_wdata;
            end
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
        if (accept)
        begin
            mode_reg      <= pbrf_pkg::mode_t'(req.mode);
            addr_reg      <= req.byte_address;
            wbyte_reg     <= req.write_byte;
            set_reg       <= req.set_bits;
            empty_reg     <= (req.rect_width == '0) || (req.rect_height == '0);
            lo_reg        <= req.x_start[2:0];
            hi_reg        <= xlast[2:0];
            bfirst_reg    <= CW'(req.x_start[8:3]);
            b_reg         <= CW'(req.x_start[8:3]);
            blast_reg     <= xlast[XW-1:3];
            rows_left_reg <= req.rect_height;
            rowbase_reg   <= FW'(row_bytes_reg) * FW'(req.y_start);
        end
        else if (advance)
        begin
            if (at_last_col)
            begin
                b_reg         <= bfirst_reg;
                rows_left_reg <= rows_left_reg - RW'(1);
                rowbase_reg   <= rowbase_reg + FW'(row_bytes_reg);
            end
            else
            begin
                b_reg <= b_reg + CW'(1);
            end
        end
        if (out_load)
        begin
            read_byte_reg <= ((mode_reg == pbrf_pkg::MODE_READ) && !flag_reg) ? ram_rdata : 8'd0;
            oor_reg       <= flag_reg;
        end
    end

    assign req.ready        = cmd.in_ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.read_byte    = read_byte_reg;
    assign rsp.out_of_range = oor_reg;

    always_comb
    begin
        sts.in_valid  = req.valid;
        sts.mode      = mode_reg;
        sts.empty     = empty_reg;
        sts.fill_oor  = fill_oor;
        sts.fill_last = fill_last;
        sts.clr_last  = (clr_cnt_reg == AW'(pbrf_pkg::MEM_BYTES - 1));
        sts.out_free  = !out_valid_reg || rsp.ready;
    end

    `PBRF_ASSERT_IMP(a_wr_after_rd, clk, rst_n, cmd.fill_wr, $past(cmd.fill_rd))
    `PBRF_ASSERT_IMP(a_wr_in_range, clk, rst_n, cmd.fill_wr, !fill_oor)
    `PBRF_ASSERT_IMP(a_wr_same_addr, clk, rst_n, cmd.fill_wr, $stable(fill_addr))
endmodule

// ===== rtl/packed_bitmap_rectangle_fill.sv =====
// Byte write or read: DISPATCH, BYTE_WR or BYTE_RD, DONE loads the response.
// Fill: FILL_RD, FILL_WR per in-range byte; FILL_RD only per skipped byte.
// Pixel rate is set by the read-modify-write on the single RAM port.
// One request in flight; the next is taken in IDLE once the response loads.
// After reset the bitmap is zeroed byte by byte with ready held low.
module packed_bitmap_rectangle_fill (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pbrf_pkg::ROW_BYTES_W-1:0] cfg_wdata,
    pbrf_in_if.sink                          req,
    pbrf_out_if.source                       rsp
);
    pbrf_pkg::cmd_t cmd;
    pbrf_pkg::sts_t sts;

    pbrf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pbrf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

// ===== sim/tb_packed_bitmap_rectangle_fill.sv =====
// Testbench for the packed bitmap rectangle fill block: mirrored bitmap, random handshakes
module tb_packed_bitmap_rectangle_fill;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_PER_SETTING = 100;

    typedef struct {
        logic [1:0]  mode;
        logic [9:0]  byte_address;
        logic [7:0]  write_byte;
        logic [8:0]  x_start;
        logic [9:0]  y_start;
        logic [9:0]  rect_width;
        logic [10:0] rect_height;
        logic        set_bits;
    } bitmap_request_t;

    typedef struct {
        logic [7:0] read_byte;
        logic       out_of_range;
    } bitmap_result_t;

    class bitmap_mirror;
        logic [7:0]                       pixels [pbrf_pkg::MEM_BYTES];
        logic [pbrf_pkg::ROW_BYTES_W-1:0] row_bytes;
        bitmap_result_t                   due_responses [$];
        int                               errors;

        function new();
            foreach (pixels[i])
                pixels[i] = 8'h00;
            row_bytes = pbrf_pkg::ROW_BYTES_RST;
            errors = 0;
        endfunction

        function void note_request(bitmap_request_t r);
            bitmap_result_t res;
            int unsigned    xlast;
            int unsigned    bfirst;
            int unsigned    blast;
            int unsigned    rowbase;
            int unsigned    addr;
            int unsigned    lo;
            int unsigned    hi;
            logic [7:0]     mask;
            res.read_byte = 8'h00;
            res.out_of_range = 1'b0;
            if (r.mode == pbrf_pkg::MODE_WRITE)
            begin
                if (r.byte_address < pbrf_pkg::MEM_BYTES)
                    pixels[r.byte_address] = r.write_byte;
                else
                    res.out_of_range = 1'b1;
            end
            else if (r.mode == pbrf_pkg::MODE_READ)
            begin
                if (r.byte_address < pbrf_pkg::MEM_BYTES)
                    res.read_byte = pixels[r.byte_address];
                else
                    res.out_of_range = 1'b1;
            end
            else if (r.mode == pbrf_pkg::MODE_FILL && r.rect_width != 0 && r.rect_height != 0)
            begin
                xlast = r.x_start + r.rect_width - 1;
                bfirst = r.x_start >> 3;
                blast = xlast >> 3;
                for (int unsigned row = 0; row < r.rect_height; row++)
                begin
                    rowbase = row_bytes * (r.y_start + row);
                    for (int unsigned b = bfirst; b <= blast; b++)
                    begin
                        lo = (b == bfirst) ? (r.x_start & 7) : 0;
                        hi = (b == blast) ? (xlast & 7) : 7;
                        mask = (8'hFF >> lo) & (8'hFF << (7 - hi));
                        addr = rowbase + b;
                        if (addr >= pbrf_pkg::MEM_BYTES)
                            res.out_of_range = 1'b1;
                        else if (r.set_bits)
                            pixels[addr] = pixels[addr] | mask;
                        else
                            pixels[addr] = pixels[addr] & ~mask;
                    end
                end
            end
            due_responses.push_back(res);
        endfunction

        task report(string what);
            $display("bitmap mismatch: %s", what);
            errors++;
        endtask

        task check_response(logic [7:0] read_byte, logic out_of_range);
            bitmap_result_t want;
            if (due_responses.size() == 0)
            begin
                report($sformatf("response with no request pending, read_byte=%02h out_of_range=%0b",
                                 read_byte, out_of_range));
                return;
            end
            want = due_responses.pop_front();
            if (read_byte !== want.read_byte)
                report($sformatf("read_byte got %02h want %02h", read_byte, want.read_byte));
            if (out_of_range !== want.out_of_range)
                report($sformatf("out_of_range got %0b want %0b", out_of_range, want.out_of_range));
        endtask
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [pbrf_pkg::ROW_BYTES_W-1:0] cfg_wdata;
    int unsigned                      cycles = 0;
    bit                               send_idle_on = 1'b1;
    bit                               take_idle_on = 1'b1;
    int                               sent = 0;
    int                               taken = 0;
    bitmap_mirror                     mirror = new();

    pbrf_in_if  req_if ();
    pbrf_out_if rsp_if ();

    packed_bitmap_rectangle_fill dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_packed_bitmap_rectangle_fill: FAIL");
            $finish;
        end
    end

    function automatic bitmap_request_t byte_request(logic [1:0] mode, logic [9:0] addr,
                                                     logic [7:0] data);
        bitmap_request_t r;
        r = '{default: '0};
        r.mode = mode;
        r.byte_address = addr;
        r.write_byte = data;
        return r;
    endfunction

    function automatic bitmap_request_t fill_request(logic [8:0] x, logic [9:0] y,
                                                     logic [9:0] w, logic [10:0] h, logic set);
        bitmap_request_t r;
        r = '{default: '0};
        r.mode = pbrf_pkg::MODE_FILL;
        r.x_start = x;
        r.y_start = y;
        r.rect_width = w;
        r.rect_height = h;
        r.set_bits = set;
        return r;
    endfunction

    function automatic bitmap_request_t random_request(logic [pbrf_pkg::ROW_BYTES_W-1:0] rb);
        bitmap_request_t r;
        int              pick;
        int              ylim;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.mode = pbrf_pkg::MODE_FILL;
        else if (pick < 65)
            r.mode = pbrf_pkg::MODE_WRITE;
        else if (pick < 95)
            r.mode = pbrf_pkg::MODE_READ;
        else
            r.mode = MODE_NONE;
        r.byte_address = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, 127));
        r.write_byte = 8'($urandom_range(0, 255));
        r.x_start = ($urandom_range(0, 4) < 3) ? 9'($urandom_range(0, 63))
                                               : 9'($urandom_range(0, 511));
        ylim = (rb == 0) ? 1023 : (1100 / rb > 1023 ? 1023 : 1100 / rb);
        r.y_start = ($urandom_range(0, 4) != 0) ? 10'($urandom_range(0, ylim))
                                                : 10'($urandom_range(0, 1023));
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            r.rect_width = 10'($urandom_range(1, 16));
            r.rect_height = 11'($urandom_range(0, 2047));
        end
        else if (pick < 5)
        begin
            r.rect_width = 10'($urandom_range(0, 1023));
            r.rect_height = 11'($urandom_range(1, 3));
        end
        else
        begin
            r.rect_width = 10'($urandom_range(0, 40));
            r.rect_height = 11'($urandom_range(0, 8));
        end
        r.set_bits = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic send_request(bitmap_request_t r);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.mode         <= r.mode;
        req_if.byte_address <= r.byte_address;
        req_if.write_byte   <= r.write_byte;
        req_if.x_start      <= r.x_start;
        req_if.y_start      <= r.y_start;
        req_if.rect_width   <= r.rect_width;
        req_if.rect_height  <= r.rect_height;
        req_if.set_bits     <= r.set_bits;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        mirror.note_request(r);
        sent++;
        if (sent % 40 == 0)
            send_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (mirror.due_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_row_bytes(logic [pbrf_pkg::ROW_BYTES_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror.row_bytes = value;
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                drain();
            send_request(random_request(mirror.row_bytes));
        end
    endtask

    initial
    begin
        int stall;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = take_idle_on ? $urandom_range(0, 5) : 0;
            if (stall != 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
            mirror.check_response(rsp_if.read_byte, rsp_if.out_of_range);
            taken++;
            if (taken % 40 == 0)
                take_idle_on = ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        logic [pbrf_pkg::ROW_BYTES_W-1:0] plan [6];
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_if.valid        = 1'b0;
        req_if.mode         = '0;
        req_if.byte_address = '0;
        req_if.write_byte   = '0;
        req_if.x_start      = '0;
        req_if.y_start      = '0;
        req_if.rect_width   = '0;
        req_if.rect_height  = '0;
        req_if.set_bits     = 1'b0;
        plan[0] = 7'd1;
        plan[1] = 7'd64;
        plan[2] = 7'd0;
        plan[3] = 7'd127;
        plan[4] = 7'($urandom_range(2, 63));
        plan[5] = 7'($urandom_range(65, 126));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(byte_request(pbrf_pkg::MODE_READ, 10'd0, 8'h00));
        send_request(byte_request(pbrf_pkg::MODE_READ, 10'd1023, 8'h00));
        send_request(byte_request(pbrf_pkg::MODE_WRITE, 10'd1023, 8'hFF));
        send_request(byte_request(pbrf_pkg::MODE_WRITE, 10'd0, 8'hA5));
        send_request(byte_request(pbrf_pkg::MODE_READ, 10'd1023, 8'h00));
        send_request(byte_request(pbrf_pkg::MODE_READ, 10'd0, 8'h00));
        send_request(fill_request(9'd0, 10'd0, 10'd0, 11'd5, 1'b1));
        send_request(fill_request(9'd0, 10'd0, 10'd5, 11'd0, 1'b1));
        send_request(fill_request(9'd3, 10'd1, 10'd2, 11'd1, 1'b1));
        send_request(fill_request(9'd5, 10'd2, 10'd20, 11'd3, 1'b1));
        send_request(byte_request(pbrf_pkg::MODE_READ, 10'd7, 8'h00));
        send_request(byte_request(pbrf_pkg::MODE_READ, 10'd15, 8'h00));
        send_request(fill_request(9'd9, 10'd2, 10'd4, 11'd2, 1'b0));
        send_request(byte_request(pbrf_pkg::MODE_READ, 10'd15, 8'h00));
        send_request('{MODE_NONE, 10'h3FF, 8'hFF, 9'h1FF, 10'h3FF, 10'd7, 11'd7, 1'b1});
        send_request(fill_request(9'd511, 10'd1023, 10'd1, 11'd1, 1'b1));
        send_request(fill_request(9'd200, 10'd3, 10'd1023, 11'd2, 1'b1));
        send_request(fill_request(9'd7, 10'd0, 10'd1, 11'd2047, 1'b0));
        send_request(fill_request(9'd1, 10'd0, 10'd512, 11'd1024, 1'b1));
        send_request(byte_request(pbrf_pkg::MODE_READ, 10'd500, 8'h00));
        send_request(fill_request(9'd0, 10'd0, 10'd56, 11'd147, 1'b0));
        send_request(byte_request(pbrf_pkg::MODE_READ, 10'd500, 8'h00));
        run_random(RANDOM_PER_SETTING);

        foreach (plan[i])
        begin
            write_row_bytes(plan[i]);
            if (plan[i] == 0)
            begin
                send_request(fill_request(9'd8, 10'd5, 10'd8, 11'd3, 1'b1));
                send_request(byte_request(pbrf_pkg::MODE_READ, 10'd1, 8'h00));
                send_request(fill_request(9'd12, 10'd900, 10'd2, 11'd2, 1'b0));
                send_request(byte_request(pbrf_pkg::MODE_READ, 10'd1, 8'h00));
            end
            run_random(RANDOM_PER_SETTING);
        end

        drain();
        repeat (20) @(posedge clk);
        if (mirror.errors == 0)
            $display("tb_packed_bitmap_rectangle_fill: PASS");
        else
            $display("tb_packed_bitmap_rectangle_fill: FAIL");
        $finish;
    end
endmodule

// ===== packed_bitmap_rectangle_fill.f =====
+incdir+rtl
rtl/pbrf_pkg.sv
rtl/pbrf_in_if.sv
rtl/pbrf_out_if.sv
rtl/pbrf_ram.sv
rtl/pbrf_ctrl.sv
rtl/pbrf_datapath.sv
rtl/packed_bitmap_rectangle_fill.sv
sim/tb_packed_bitmap_rectangle_fill.sv
